@@ sv/dtpr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtpr_pkg
// Shared types and constants of the disparity to point reprojection block:
// request and response payloads, register indexes and divider lane types.
// ----------------------------------------------------------------------------
package dtpr_pkg;

   // Field and register widths
   localparam int unsigned RAW_W      = 16;
   localparam int unsigned POS_W      = 12;
   localparam int unsigned COORD_W    = 32;
   localparam int unsigned DISP_W     = 32;
   localparam int unsigned FOCAL_W    = 24;
   localparam int unsigned BASE_W     = 20;
   localparam int unsigned SCALE_W    = 24;
   localparam int unsigned DIM_W      = 13;
   localparam int unsigned CSR_IDX_W  = 8;
   localparam int unsigned CSR_DATA_W = 32;

   // Arithmetic widths
   localparam int unsigned PROD_W     = SCALE_W + RAW_W;         // raw disparity product
   localparam int unsigned OFS_W      = POS_W + 2;               // signed half-pixel offset
   localparam int unsigned MAG_W      = POS_W + 1;               // offset magnitude
   localparam int unsigned LAT_SHIFT  = 11;
   localparam int unsigned Z_SHIFT    = 4;
   localparam int unsigned LPROD_W    = MAG_W + BASE_W;
   localparam int unsigned FB_W       = FOCAL_W + BASE_W;
   localparam int unsigned NUM_L_W    = LPROD_W + LAT_SHIFT;     // lateral numerator
   localparam int unsigned NUM_Z_W    = FB_W + Z_SHIFT;          // depth numerator
   localparam int unsigned QUO_W      = 32;                      // quotient bits computed

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL_LENGTH   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASELINE       = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COORD_SCALE    = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INVALID_VALUE  = 8'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INVALID_ENABLE = 8'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH    = 8'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT   = 8'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_BIG_ENDIAN     = 8'd7;

   // Register reset values
   localparam logic [SCALE_W-1:0] COORD_SCALE_RST  = 24'd65536;
   localparam logic [DIM_W-1:0]   IMAGE_WIDTH_RST  = 13'd640;
   localparam logic [DIM_W-1:0]   IMAGE_HEIGHT_RST = 13'd480;

   // Saturation limits
   localparam logic [COORD_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] NEG_LIMIT = 32'h8000_0000;
   localparam logic [COORD_W-1:0] U_LIMIT   = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [RAW_W-1:0] disparity_raw;
      logic [POS_W-1:0] column;
      logic [POS_W-1:0] row;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic [COORD_W-1:0]        point_z;
      logic                      point_valid;
   } rsp_type;

   // Per-item flags carried alongside the divider lanes
   typedef struct packed {
      logic point_valid;
      logic neg_x;
      logic neg_y;
      logic ovf_x;
      logic ovf_y;
      logic ovf_z;
   } side_type;

   // One divider lane: partial remainder and numerator bits / quotient bits
   typedef struct packed {
      logic [QUO_W-1:0] rem;
      logic [QUO_W-1:0] low;
   } div_lane_type;

endpackage

@@ sv/dtpr_div_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtpr_div_pipe
// Pipelined restoring divider, three lanes sharing one divisor. Each stage
// retires one quotient bit per lane; the low word shifts numerator bits out
// and quotient bits in, so it holds the quotient after the last stage.
// ----------------------------------------------------------------------------
module dtpr_div_pipe (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [31:0]             in_d,
   input  dtpr_pkg::side_type      in_side,
   input  dtpr_pkg::div_lane_type  in_x,
   input  dtpr_pkg::div_lane_type  in_y,
   input  dtpr_pkg::div_lane_type  in_z,
   output logic                    out_valid,
   output logic [31:0]             out_d,
   output dtpr_pkg::side_type      out_side,
   output logic [31:0]             out_qx,
   output logic [31:0]             out_qy,
   output logic [31:0]             out_qz
);
   import dtpr_pkg::*;

   // One compare-subtract step; the remainder is below d on entry
   function automatic div_lane_type div_step(div_lane_type lane, logic [DISP_W-1:0] d);
      logic [QUO_W:0] trial;
      logic [QUO_W:0] diff;
      div_lane_type   nxt;
      trial = {lane.rem, lane.low[QUO_W-1]};
      diff  = trial - {1'b0, d};
      if (!diff[QUO_W]) begin
         nxt.rem = diff[QUO_W-1:0];
         nxt.low = {lane.low[QUO_W-2:0], 1'b1};
      end else begin
         nxt.rem = trial[QUO_W-1:0];
         nxt.low = {lane.low[QUO_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

   logic [QUO_W-1:0] valid_ff;
   logic [DISP_W-1:0] d_ff [QUO_W];
   side_type          side_ff [QUO_W];
   div_lane_type      x_ff [QUO_W];
   div_lane_type      y_ff [QUO_W];
   div_lane_type      z_ff [QUO_W];

   div_lane_type      x_in [QUO_W];
   div_lane_type      y_in [QUO_W];
   div_lane_type      z_in [QUO_W];

   // Stage taps: tap 0 is the pipe input, tap s+1 the output of stage s
   logic [QUO_W:0]    valid_tap;
   logic [DISP_W-1:0] d_tap [QUO_W+1];
   side_type          side_tap [QUO_W+1];
   div_lane_type      x_tap [QUO_W+1];
   div_lane_type      y_tap [QUO_W+1];
   div_lane_type      z_tap [QUO_W+1];

   assign valid_tap[0] = in_valid;
   assign d_tap[0]     = in_d;
   assign side_tap[0]  = in_side;
   assign x_tap[0]     = in_x;
   assign y_tap[0]     = in_y;
   assign z_tap[0]     = in_z;

   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      assign x_in[s] = div_step(x_tap[s], d_tap[s]);
      assign y_in[s] = div_step(y_tap[s], d_tap[s]);
      assign z_in[s] = div_step(z_tap[s], d_tap[s]);

      // advance the valid bit
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_tap[s];
         end
      end

      // advance the payload only behind a valid request
      always_ff @(posedge clock) begin
         if (valid_tap[s]) begin
            d_ff[s]    <= d_tap[s];
            side_ff[s] <= side_tap[s];
            x_ff[s]    <= x_in[s];
            y_ff[s]    <= y_in[s];
            z_ff[s]    <= z_in[s];
         end
      end

      assign valid_tap[s+1] = valid_ff[s];
      assign d_tap[s+1]     = d_ff[s];
      assign side_tap[s+1]  = side_ff[s];
      assign x_tap[s+1]     = x_ff[s];
      assign y_tap[s+1]     = y_ff[s];
      assign z_tap[s+1]     = z_ff[s];
   end

   assign out_valid = valid_tap[QUO_W];
   assign out_d     = d_tap[QUO_W];
   assign out_side  = side_tap[QUO_W];
   assign out_qx    = x_tap[QUO_W].low;
   assign out_qy    = y_tap[QUO_W].low;
   assign out_qz    = z_tap[QUO_W].low;

endmodule

@@ sv/disparity_to_point_reprojection.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disparity_to_point_reprojection
// Scales a raw disparity pixel and reprojects it to a 3D point (x, y, z) in
// 2^-16 m, using focal length, baseline and image center from registers.
// ----------------------------------------------------------------------------
//  Channel   Ports                          Handshake
//  request   start, busy, req_data          taken when start & !busy
//  response  rsp_valid, rsp_data            one-cycle strobe, no back-pressure
//  config    csr_valid, csr_ready,          written when csr_valid & csr_ready
//            csr_index, csr_data
//
//  One request enters every cycle; busy is never raised. Each response passes
//  three front stages (disparity scale, numerator products, overflow check),
//  32 divider stages that retire one quotient bit each, and the output
//  register. Reset clears all valid bits and loads the register reset values.
//  Responses cannot stall, so nothing in the pipe waits.
// ----------------------------------------------------------------------------
module disparity_to_point_reprojection #(
   parameter int unsigned MAX_DIM = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  dtpr_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   output dtpr_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dtpr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dtpr_pkg::CSR_DATA_W-1:0]      csr_data
);
   import dtpr_pkg::*;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [FOCAL_W-1:0] focal_length_ff;
   logic [BASE_W-1:0]  baseline_ff;
   logic [SCALE_W-1:0] coord_scale_ff;
   logic [DISP_W-1:0]  invalid_value_ff;
   logic               invalid_enable_ff;
   logic [DIM_W-1:0]   image_width_ff;
   logic [DIM_W-1:0]   image_height_ff;
   logic               big_endian_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   // write one register per accepted request on the config channel
   always_ff @(posedge clock) begin
      if (reset) begin
         focal_length_ff   <= '0;
         baseline_ff       <= '0;
         coord_scale_ff    <= COORD_SCALE_RST;
         invalid_value_ff  <= '0;
         invalid_enable_ff <= 1'b0;
         image_width_ff    <= IMAGE_WIDTH_RST;
         image_height_ff   <= IMAGE_HEIGHT_RST;
         big_endian_ff     <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FOCAL_LENGTH:   focal_length_ff   <= csr_data[FOCAL_W-1:0];
            CSR_BASELINE:       baseline_ff       <= csr_data[BASE_W-1:0];
            CSR_COORD_SCALE:    coord_scale_ff    <= csr_data[SCALE_W-1:0];
            CSR_INVALID_VALUE:  invalid_value_ff  <= csr_data[DISP_W-1:0];
            CSR_INVALID_ENABLE: invalid_enable_ff <= csr_data[0];
            CSR_IMAGE_WIDTH:    image_width_ff    <= csr_data[DIM_W-1:0];
            CSR_IMAGE_HEIGHT:   image_height_ff   <= csr_data[DIM_W-1:0];
            CSR_BIG_ENDIAN:     big_endian_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: byte order, disparity scale, focal*baseline, center offsets
   // ---------------------------------------------------------------------
   logic               accept;
   logic [RAW_W-1:0]   word;
   logic [DIM_W-1:0]   width_clamp;
   logic [DIM_W-1:0]   height_clamp;
   logic [OFS_W-1:0]   ofs_x;
   logic [OFS_W-1:0]   ofs_y;
   logic [OFS_W-1:0]   abs_x;
   logic [OFS_W-1:0]   abs_y;

   logic               s1_valid_ff;
   logic [PROD_W-1:0]  s1_prod_ff;
   logic [PROD_W-1:0]  s1_prod_in;
   logic [FB_W-1:0]    s1_fb_ff;
   logic [FB_W-1:0]    s1_fb_in;
   logic [MAG_W-1:0]   s1_mag_x_ff;
   logic [MAG_W-1:0]   s1_mag_y_ff;
   logic               s1_neg_x_ff;
   logic               s1_neg_y_ff;

   assign accept = start && !busy;

   always_comb begin
      word = big_endian_ff ? {req_data.disparity_raw[7:0], req_data.disparity_raw[15:8]}
                           : req_data.disparity_raw;
      s1_prod_in = PROD_W'(coord_scale_ff) * PROD_W'(word);
      s1_fb_in   = FB_W'(focal_length_ff) * FB_W'(baseline_ff);

      width_clamp  = (32'(image_width_ff) > MAX_DIM) ? DIM_W'(MAX_DIM) : image_width_ff;
      height_clamp = (32'(image_height_ff) > MAX_DIM) ? DIM_W'(MAX_DIM) : image_height_ff;

      // offsets in half pixels: 2*pos + 1 - dim
      ofs_x = OFS_W'({req_data.column, 1'b1}) - OFS_W'(width_clamp);
      ofs_y = OFS_W'({req_data.row, 1'b1}) - OFS_W'(height_clamp);
      abs_x = ofs_x[OFS_W-1] ? (~ofs_x + 1'b1) : ofs_x;
      abs_y = ofs_y[OFS_W-1] ? (~ofs_y + 1'b1) : ofs_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_prod_ff  <= s1_prod_in;
         s1_fb_ff    <= s1_fb_in;
         s1_mag_x_ff <= abs_x[MAG_W-1:0];
         s1_mag_y_ff <= abs_y[MAG_W-1:0];
         s1_neg_x_ff <= ofs_x[OFS_W-1];
         s1_neg_y_ff <= ofs_y[OFS_W-1];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: saturate d, validity check, lateral products
   // ---------------------------------------------------------------------
   logic [DISP_W-1:0]  s2_d_in;
   logic               s2_pv_in;

   logic               s2_valid_ff;
   logic [DISP_W-1:0]  s2_d_ff;
   logic               s2_pv_ff;
   logic [LPROD_W-1:0] s2_px_ff;
   logic [LPROD_W-1:0] s2_py_ff;
   logic [FB_W-1:0]    s2_fb_ff;
   logic               s2_neg_x_ff;
   logic               s2_neg_y_ff;

   always_comb begin
      s2_d_in  = (|s1_prod_ff[PROD_W-1:DISP_W]) ? U_LIMIT : s1_prod_ff[DISP_W-1:0];
      s2_pv_in = (s2_d_in != '0) && !(invalid_enable_ff && (s2_d_in == invalid_value_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_d_ff     <= s2_d_in;
         s2_pv_ff    <= s2_pv_in;
         s2_px_ff    <= LPROD_W'(s1_mag_x_ff) * LPROD_W'(baseline_ff);
         s2_py_ff    <= LPROD_W'(s1_mag_y_ff) * LPROD_W'(baseline_ff);
         s2_fb_ff    <= s1_fb_ff;
         s2_neg_x_ff <= s1_neg_x_ff;
         s2_neg_y_ff <= s1_neg_y_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: numerators, quotient overflow check, divider lane setup
   // ---------------------------------------------------------------------
   logic [NUM_L_W-1:0] num_x;
   logic [NUM_L_W-1:0] num_y;
   logic [NUM_Z_W-1:0] num_z;
   side_type           s3_side_in;
   div_lane_type       s3_x_in;
   div_lane_type       s3_y_in;
   div_lane_type       s3_z_in;

   logic               s3_valid_ff;
   logic [DISP_W-1:0]  s3_d_ff;
   side_type           s3_side_ff;
   div_lane_type       s3_x_ff;
   div_lane_type       s3_y_ff;
   div_lane_type       s3_z_ff;

   // quotient reaches 2^32 exactly when the numerator bits above 32 reach d
   always_comb begin
      num_x = {s2_px_ff, LAT_SHIFT'(0)};
      num_y = {s2_py_ff, LAT_SHIFT'(0)};
      num_z = {s2_fb_ff, Z_SHIFT'(0)};

      s3_side_in.point_valid = s2_pv_ff;
      s3_side_in.neg_x       = s2_neg_x_ff;
      s3_side_in.neg_y       = s2_neg_y_ff;
      s3_side_in.ovf_x       = QUO_W'(num_x[NUM_L_W-1:QUO_W]) >= s2_d_ff;
      s3_side_in.ovf_y       = QUO_W'(num_y[NUM_L_W-1:QUO_W]) >= s2_d_ff;
      s3_side_in.ovf_z       = QUO_W'(num_z[NUM_Z_W-1:QUO_W]) >= s2_d_ff;

      s3_x_in.rem = QUO_W'(num_x[NUM_L_W-1:QUO_W]);
      s3_x_in.low = num_x[QUO_W-1:0];
      s3_y_in.rem = QUO_W'(num_y[NUM_L_W-1:QUO_W]);
      s3_y_in.low = num_y[QUO_W-1:0];
      s3_z_in.rem = QUO_W'(num_z[NUM_Z_W-1:QUO_W]);
      s3_z_in.low = num_z[QUO_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         s3_d_ff    <= s2_d_ff;
         s3_side_ff <= s3_side_in;
         s3_x_ff    <= s3_x_in;
         s3_y_ff    <= s3_y_in;
         s3_z_ff    <= s3_z_in;
      end
   end

   // ---------------------------------------------------------------------
   // Divider pipeline
   // ---------------------------------------------------------------------
   logic               dv_valid;
   logic [DISP_W-1:0]  dv_d;
   side_type           dv_side;
   logic [QUO_W-1:0]   dv_qx;
   logic [QUO_W-1:0]   dv_qy;
   logic [QUO_W-1:0]   dv_qz;

   dtpr_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_d      (s3_d_ff),
      .in_side   (s3_side_ff),
      .in_x      (s3_x_ff),
      .in_y      (s3_y_ff),
      .in_z      (s3_z_ff),
      .out_valid (dv_valid),
      .out_d     (dv_d),
      .out_side  (dv_side),
      .out_qx    (dv_qx),
      .out_qy    (dv_qy),
      .out_qz    (dv_qz)
   );

   // ---------------------------------------------------------------------
   // Output stage: sign, saturate, drop invalid points to zero
   // ---------------------------------------------------------------------
   function automatic logic [COORD_W-1:0] lateral_sat(logic neg, logic ovf,
                                                      logic [QUO_W-1:0] q);
      logic [COORD_W-1:0] res;
      if (neg) begin
         res = (ovf || (q > NEG_LIMIT)) ? NEG_LIMIT : (~q + 1'b1);
      end else begin
         res = (ovf || q[QUO_W-1]) ? POS_LIMIT : q;
      end
      return res;
   endfunction

   rsp_type rsp_data_in;
   rsp_type rsp_data_ff;
   logic    rsp_valid_ff;

   always_comb begin
      if (dv_side.point_valid) begin
         rsp_data_in.point_x     = lateral_sat(dv_side.neg_x, dv_side.ovf_x, dv_qx);
         rsp_data_in.point_y     = lateral_sat(dv_side.neg_y, dv_side.ovf_y, dv_qy);
         rsp_data_in.point_z     = dv_side.ovf_z ? U_LIMIT : dv_qz;
         rsp_data_in.point_valid = 1'b1;
      end else begin
         rsp_data_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid;
      end
   end

   // load the response register behind each valid divider output (d is never zero for a valid point)
   always_ff @(posedge clock) begin
      if (dv_valid && (dv_d != '0 || !dv_side.point_valid)) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
